// ----- rtl/rfp_pkg.sv -----
// rfp_pkg: constants, register indexes and controller/datapath types for
// rx_fifo_frame_packer. No dependencies.
package rfp_pkg;

    localparam int BYTE_W    = 8;
    localparam int LIMIT_W   = 6;
    localparam int REG_IDX_W = 2;

    localparam logic [BYTE_W-1:0]  FRAME_START = 8'h02;
    localparam logic [BYTE_W-1:0]  FRAME_TAG   = 8'h81;
    localparam logic [LIMIT_W-1:0] MAX_PAYLOAD = 6'd59;
    localparam logic [BYTE_W-1:0]  IDLE_MAX    = 8'hFF;

    localparam logic [REG_IDX_W-1:0] REG_FLUSH_LIMIT  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_IDLE_TIMEOUT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COMMAND_BYTE = 2'd2;

    localparam logic [LIMIT_W-1:0] FLUSH_LIMIT_RST  = 6'd59;
    localparam logic [BYTE_W-1:0]  IDLE_TIMEOUT_RST = 8'd10;
    localparam logic [BYTE_W-1:0]  COMMAND_RST      = 8'd0;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [2:0] {
        SEL_START,
        SEL_TAG,
        SEL_CMD,
        SEL_LEN,
        SEL_PAY,
        SEL_SUM
    } out_sel_t;

    typedef struct packed {
        logic     accept;
        logic     load_frame;
        logic     clear_idle;
        logic     emit;
        out_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic ring_empty;
        logic frame_due;
        logic cnt_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- rtl/rfp_if.sv -----
// rfp_if: request channel interfaces for rx_fifo_frame_packer.
// Depends on rfp_pkg.
interface rfp_in_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [rfp_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface rfp_out_if;
    logic                      valid;
    logic                      ready;
    logic [rfp_pkg::BYTE_W-1:0] frame_byte;
    logic                      last;

    modport source (output valid, output frame_byte, output last, input ready);
    modport sink   (input valid, input frame_byte, input last, output ready);
endinterface

interface rfp_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [rfp_pkg::REG_IDX_W-1:0] index;
    logic [rfp_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/rfp_ctrl.sv -----
// rfp_ctrl: frame sequencer for rx_fifo_frame_packer.
// Depends on rfp_pkg; drives rfp_dp through dp_cmd_t, reads dp_stat_t.
module rfp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rfp_pkg::dp_stat_t stat,
    output rfp_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_START,
        ST_TAG,
        ST_CMD,
        ST_LEN,
        ST_PAY,
        ST_SUM
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.sel        = rfp_pkg::SEL_START;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.ring_empty)
                begin
                    cmd.clear_idle = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (stat.frame_due)
                begin
                    cmd.load_frame = 1'b1;
                    state_next     = ST_START;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_START:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = rfp_pkg::SEL_START;
                if (stat.out_free)
                begin
                    state_next = ST_TAG;
                end
            end
            ST_TAG:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = rfp_pkg::SEL_TAG;
                if (stat.out_free)
                begin
                    state_next = ST_CMD;
                end
            end
            ST_CMD:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = rfp_pkg::SEL_CMD;
                if (stat.out_free)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = rfp_pkg::SEL_LEN;
                if (stat.out_free)
                begin
                    state_next = ST_PAY;
                end
            end
            ST_PAY:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = rfp_pkg::SEL_PAY;
                if (stat.out_free && stat.cnt_last)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = rfp_pkg::SEL_SUM;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/rfp_dp.sv -----
// rfp_dp: ring memory, pointers, idle counter, config registers, checksum
// and output register for rx_fifo_frame_packer. Depends on rfp_pkg.
module rfp_dp #(
    parameter int RING_DEPTH = 64
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  rfp_pkg::dp_cmd_t                 cmd,
    output rfp_pkg::dp_stat_t                stat,
    input  logic                             kind,
    input  logic [rfp_pkg::BYTE_W-1:0]       rx_byte,
    input  logic                             cfg_we,
    input  logic [rfp_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [rfp_pkg::BYTE_W-1:0]       cfg_data,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [rfp_pkg::BYTE_W-1:0]       frame_byte,
    output logic                             last
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(RING_DEPTH);

    logic [rfp_pkg::BYTE_W-1:0] ring_mem [RING_DEPTH];

    logic [PTR_W-1:0]            wptr_reg, wptr_next;
    logic [PTR_W-1:0]            rptr_reg, rptr_next;
    logic [CNT_W-1:0]            fill_reg, fill_next;
    logic [rfp_pkg::BYTE_W-1:0]  idle_reg, idle_next;
    logic [rfp_pkg::LIMIT_W-1:0] limit_reg;
    logic [rfp_pkg::BYTE_W-1:0]  timeout_reg;
    logic [rfp_pkg::BYTE_W-1:0]  command_reg;
    logic [rfp_pkg::LIMIT_W-1:0] cnt_reg, cnt_next;
    logic [rfp_pkg::BYTE_W-1:0]  check_reg, check_next;
    logic [rfp_pkg::BYTE_W-1:0]  rd_data_reg;
    logic                        out_valid_reg;
    logic [rfp_pkg::BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic                        out_last_reg;

    logic                        store, tick, out_free, pop, over;
    logic [rfp_pkg::LIMIT_W-1:0] eff_limit, n_len;

    assign store    = cmd.accept && (kind == rfp_pkg::KIND_BYTE) && (fill_reg != FILL_FULL);
    assign tick     = cmd.accept && (kind == rfp_pkg::KIND_TICK);
    assign out_free = !out_valid_reg || out_ready;
    assign pop      = cmd.emit && out_free && (cmd.sel == rfp_pkg::SEL_PAY);

    always_comb
    begin
        wptr_next = wptr_reg;
        if (store)
        begin
            wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + PTR_W'(1);
        end
        rptr_next = rptr_reg;
        if (pop)
        begin
            rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + PTR_W'(1);
        end
        fill_next = fill_reg;
        if (store)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
        idle_next = idle_reg;
        if (cmd.load_frame || cmd.clear_idle)
        begin
            idle_next = '0;
        end
        else if (tick && (idle_reg != rfp_pkg::IDLE_MAX))
        begin
            idle_next = idle_reg + 8'd1;
        end
    end

    // limit 0 acts as 1, above the frame maximum acts as the maximum
    always_comb
    begin
        if (limit_reg == '0)
        begin
            eff_limit = rfp_pkg::LIMIT_W'(1);
        end
        else if (limit_reg > rfp_pkg::MAX_PAYLOAD)
        begin
            eff_limit = rfp_pkg::MAX_PAYLOAD;
        end
        else
        begin
            eff_limit = limit_reg;
        end
    end

    assign over  = fill_reg > CNT_W'(eff_limit);
    assign n_len = over ? eff_limit : fill_reg[rfp_pkg::LIMIT_W-1:0];

    assign stat.ring_empty = (fill_reg == '0);
    assign stat.frame_due  = over || (idle_reg > timeout_reg);
    assign stat.cnt_last   = (cnt_reg == rfp_pkg::LIMIT_W'(1));
    assign stat.out_free   = out_free;

    always_comb
    begin
        cnt_next   = cnt_reg;
        check_next = check_reg;
        if (cmd.load_frame)
        begin
            cnt_next   = n_len;
            check_next = rfp_pkg::FRAME_TAG ^ command_reg ^ rfp_pkg::BYTE_W'(n_len);
        end
        else if (pop)
        begin
            cnt_next   = cnt_reg - rfp_pkg::LIMIT_W'(1);
            check_next = check_reg ^ rd_data_reg;
        end
    end

    always_comb
    begin
        case (cmd.sel)
            rfp_pkg::SEL_START: out_byte_next = rfp_pkg::FRAME_START;
            rfp_pkg::SEL_TAG:   out_byte_next = rfp_pkg::FRAME_TAG;
            rfp_pkg::SEL_CMD:   out_byte_next = command_reg;
            rfp_pkg::SEL_LEN:   out_byte_next = rfp_pkg::BYTE_W'(cnt_reg);
            rfp_pkg::SEL_PAY:   out_byte_next = rd_data_reg;
            rfp_pkg::SEL_SUM:   out_byte_next = check_reg;
            default:            out_byte_next = check_reg;
        endcase
    end

    // read port tracks next read pointer: one byte per cycle while out_free
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            ring_mem[wptr_reg] <= rx_byte;
        end
        rd_data_reg <= ring_mem[rptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            fill_reg      <= '0;
            idle_reg      <= '0;
            limit_reg     <= rfp_pkg::FLUSH_LIMIT_RST;
            timeout_reg   <= rfp_pkg::IDLE_TIMEOUT_RST;
            command_reg   <= rfp_pkg::COMMAND_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
            idle_reg <= idle_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    rfp_pkg::REG_FLUSH_LIMIT:  limit_reg   <= cfg_data[rfp_pkg::LIMIT_W-1:0];
                    rfp_pkg::REG_IDLE_TIMEOUT: timeout_reg <= cfg_data;
                    rfp_pkg::REG_COMMAND_BYTE: command_reg <= cfg_data;
                    default:                   ;
                endcase
            end
            if (cmd.emit && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        check_reg <= check_next;
        if (cmd.emit && out_free)
        begin
            out_byte_reg <= out_byte_next;
            out_last_reg <= (cmd.sel == rfp_pkg::SEL_SUM);
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign last       = out_last_reg;

endmodule

// ----- rtl/rx_fifo_frame_packer.sv -----
// rx_fifo_frame_packer: top level, joins rfp_ctrl and rfp_dp to the channels.
// Depends on rfp_pkg, rfp_if, rfp_ctrl, rfp_dp.
//
// Usage:
//   rx  - requests of kind 0 (received byte) or 1 (timer tick).
//   tx  - frame bytes: 0x02, 0x81, command, length, payload, XOR checksum;
//         last marks the checksum byte.
//   cfg - register writes (0 flush_limit, 1 idle_timeout, 2 command_byte),
//         always ready; write only while the block is idle.
// Timing: one request at a time. A request that sends no frame has the accept,
//   then the frame check. A request that sends a frame of n payload bytes goes
//   on through the start, tag, command, length, payload and checksum
//   states, one frame byte per cycle while tx.ready does not hold the output
//   register; the payload comes from the ring memory's registered read port.
// The output register holds a byte while tx.ready is low; the sequencer then
//   waits and rx stays not ready until the checksum byte is loaded.
// Reset empties the ring, clears the idle count, sets flush_limit 59,
//   idle_timeout 10, command_byte 0; ring contents are not cleared.
module rx_fifo_frame_packer #(
    parameter int RING_DEPTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    rfp_in_if.sink     rx,
    rfp_out_if.source  tx,
    rfp_cfg_if.sink    cfg
);

    rfp_pkg::dp_cmd_t  cmd;
    rfp_pkg::dp_stat_t stat;

    assign cfg.ready = 1'b1;

    rfp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rfp_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .kind       (rx.kind),
        .rx_byte    (rx.rx_byte),
        .cfg_we     (cfg.valid && cfg.ready),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .out_ready  (tx.ready),
        .out_valid  (tx.valid),
        .frame_byte (tx.frame_byte),
        .last       (tx.last)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (rx.valid && rx.ready) |=> !rx.ready)
        else $error("rx ready right after an accepted request");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.sel == rfp_pkg::SEL_PAY) |-> !stat.ring_empty)
        else $error("payload read from an empty ring");

    a_frame_only_when_due: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_frame |-> (stat.frame_due && !stat.ring_empty))
        else $error("frame started without a due condition");

endmodule
